/* rtl/rau_pkg.sv */
package rau_pkg;

   localparam int WORD_BITS = 64;
   localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_GT  = 3'd3,
      OP_EQ  = 3'd4
   } op_type;

   // datapath micro-operations
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,       // capture operands
      DP_RED_A,      // load gcd unit with a.num, a.den
      DP_DIV_A,      // a /= g (start divides)
      DP_RED_B,
      DP_DIV_B,
      DP_GCD_DEN,    // gcd(a.den, b.den)
      DP_LCM,        // l = (a.den*b.den)/g
      DP_SCALE,      // l/a.den, l/b.den
      DP_MULS,       // sa, sb
      DP_COMBINE,    // sum / difference
      DP_MUL,        // products for multiply
      DP_RED_R,      // gcd of result
      DP_DIV_R       // result /= g
   } cmd_type;

   typedef struct packed {
      logic    go;
      cmd_type cmd;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
   } dp_sts_type;

endpackage

/* rtl/rau_divider.sv */
// restoring divider, one quotient bit per cycle
module rau_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rau_pkg::word_type   dividend,
   input  rau_pkg::word_type   divisor,
   output logic                done,
   output rau_pkg::word_type   quotient,
   output rau_pkg::word_type   remainder
);
   rau_pkg::word_type q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [rau_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [rau_pkg::WORD_BITS:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[rau_pkg::WORD_BITS-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = rau_pkg::CNT_BITS'(rau_pkg::WORD_BITS); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[rau_pkg::WORD_BITS]) begin
            r_in = trial[rau_pkg::WORD_BITS-1:0];
            q_in = {q_ff[rau_pkg::WORD_BITS-2:0], 1'b1};
         end else begin
            r_in = {r_ff[rau_pkg::WORD_BITS-2:0], q_ff[rau_pkg::WORD_BITS-1]};
            q_in = {q_ff[rau_pkg::WORD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rau_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

/* rtl/rau_datapath.sv */
module rau_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::dp_cmd_type  cmd,
   output rau_pkg::dp_sts_type  sts,
   input  logic [2:0]           op,
   input  rau_pkg::word_type    a_num_i,
   input  rau_pkg::word_type    a_den_i,
   input  logic                 a_neg_i,
   input  rau_pkg::word_type    b_num_i,
   input  rau_pkg::word_type    b_den_i,
   input  logic                 b_neg_i,
   output rau_pkg::word_type    r_num,
   output rau_pkg::word_type    r_den,
   output logic                 r_neg
);
   localparam int HB = rau_pkg::WORD_BITS / 2;
   typedef enum logic [2:0] {S_IDLE, S_GCD, S_GDIV, S_DIV1, S_DIV2, S_MUL} sub_type;

   sub_type sub_ff;
   logic done_ff;
   rau_pkg::cmd_type cur_ff;
   rau_pkg::word_type an_ff, ad_ff, bn_ff, bd_ff, rn_ff, rd_ff;
   logic an_neg_ff, bn_neg_ff, rneg_ff;
   rau_pkg::word_type gx_ff, gy_ff, g_ff, l_ff, ka_ff, kb_ff;
   rau_pkg::word_type ma_ff, mb_ff, acc_ff;
   logic [1:0] mstep_ff, mpair_ff;

   logic dv_start;
   rau_pkg::word_type dv_n, dv_d, dv_q, dv_r;
   logic dv_done;
   logic [HB-1:0] mul_x, mul_y;
   logic [rau_pkg::WORD_BITS-1:0] pp;

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_n),
      .divisor(dv_d), .done(dv_done), .quotient(dv_q), .remainder(dv_r)
   );

   // 64x64 wrapped product as three 32x32 partial products over cycles
   always_comb begin
      unique case (mstep_ff)
         2'd0: begin
            mul_x = ma_ff[HB-1:0]; mul_y = mb_ff[HB-1:0];
         end
         2'd1: begin
            mul_x = ma_ff[HB-1:0]; mul_y = mb_ff[rau_pkg::WORD_BITS-1:HB];
         end
         default: begin
            mul_x = ma_ff[rau_pkg::WORD_BITS-1:HB]; mul_y = mb_ff[HB-1:0];
         end
      endcase
      pp = rau_pkg::word_type'(mul_x) * rau_pkg::word_type'(mul_y);
      if (mstep_ff != 2'd0) pp = pp << HB;
   end

   always_ff @(posedge clock) begin
      dv_start <= 1'b0;
      done_ff <= 1'b0;
      if (reset) begin
         sub_ff <= S_IDLE;
      end else begin
         unique case (sub_ff)
            S_IDLE: if (cmd.go) begin
               cur_ff <= cmd.cmd;
               unique case (cmd.cmd)
                  rau_pkg::DP_LOAD: begin
                     an_ff <= a_num_i; ad_ff <= a_den_i; an_neg_ff <= a_neg_i;
                     bn_ff <= b_num_i; bd_ff <= b_den_i;
                     bn_neg_ff <= (op == 3'(rau_pkg::OP_ADD)) ? b_neg_i : !b_neg_i;
                     done_ff <= 1'b1;
                  end
                  rau_pkg::DP_RED_A: begin
                     gx_ff <= an_ff; gy_ff <= ad_ff; sub_ff <= S_GCD;
                  end
                  rau_pkg::DP_RED_B: begin
                     gx_ff <= bn_ff; gy_ff <= bd_ff; sub_ff <= S_GCD;
                  end
                  rau_pkg::DP_GCD_DEN: begin
                     gx_ff <= ad_ff; gy_ff <= bd_ff; sub_ff <= S_GCD;
                  end
                  rau_pkg::DP_RED_R: begin
                     gx_ff <= rn_ff; gy_ff <= rd_ff; sub_ff <= S_GCD;
                  end
                  rau_pkg::DP_DIV_A: begin
                     dv_n <= an_ff; dv_d <= g_ff; dv_start <= 1'b1; sub_ff <= S_DIV1;
                  end
                  rau_pkg::DP_DIV_B: begin
                     dv_n <= bn_ff; dv_d <= g_ff; dv_start <= 1'b1; sub_ff <= S_DIV1;
                  end
                  rau_pkg::DP_DIV_R: begin
                     dv_n <= rn_ff; dv_d <= g_ff; dv_start <= 1'b1; sub_ff <= S_DIV1;
                  end
                  rau_pkg::DP_LCM: begin
                     ma_ff <= ad_ff; mb_ff <= bd_ff; acc_ff <= '0;
                     mstep_ff <= 2'd0; mpair_ff <= 2'd0; sub_ff <= S_MUL;
                  end
                  rau_pkg::DP_SCALE: begin
                     dv_n <= l_ff; dv_d <= ad_ff; dv_start <= 1'b1; sub_ff <= S_DIV1;
                  end
                  rau_pkg::DP_MULS: begin
                     ma_ff <= an_ff; mb_ff <= ka_ff; acc_ff <= '0;
                     mstep_ff <= 2'd0; mpair_ff <= 2'd0; sub_ff <= S_MUL;
                  end
                  rau_pkg::DP_MUL: begin
                     ma_ff <= an_ff; mb_ff <= bn_ff; acc_ff <= '0;
                     rneg_ff <= an_neg_ff ^ b_neg_i;
                     mstep_ff <= 2'd0; mpair_ff <= 2'd0; sub_ff <= S_MUL;
                  end
                  rau_pkg::DP_COMBINE: begin
                     rd_ff <= l_ff;
                     if (an_neg_ff == bn_neg_ff) begin
                        rn_ff <= ka_ff + kb_ff; rneg_ff <= an_neg_ff;
                     end else if (ka_ff >= kb_ff) begin
                        rn_ff <= ka_ff - kb_ff; rneg_ff <= an_neg_ff;
                     end else begin
                        rn_ff <= kb_ff - ka_ff; rneg_ff <= bn_neg_ff;
                     end
                     done_ff <= 1'b1;
                  end
                  default: done_ff <= 1'b1;
               endcase
            end
            S_GCD: begin
               if (gy_ff == '0) begin
                  g_ff <= (gx_ff == '0) ? rau_pkg::WORD_BITS'(1) : gx_ff;
                  sub_ff <= S_IDLE;
                  done_ff <= 1'b1;
               end else begin
                  dv_n <= gx_ff; dv_d <= gy_ff; dv_start <= 1'b1; sub_ff <= S_GDIV;
               end
            end
            S_GDIV: if (dv_done) begin
               gx_ff <= gy_ff; gy_ff <= dv_r; sub_ff <= S_GCD;
            end
            S_DIV1: if (dv_done) begin
               unique case (cur_ff)
                  rau_pkg::DP_DIV_A: begin
                     an_ff <= dv_q; dv_n <= ad_ff;
                  end
                  rau_pkg::DP_DIV_B: begin
                     bn_ff <= dv_q; dv_n <= bd_ff;
                  end
                  rau_pkg::DP_DIV_R: begin
                     rn_ff <= dv_q; dv_n <= rd_ff;
                  end
                  rau_pkg::DP_LCM: begin
                     l_ff <= dv_q;
                  end
                  default: begin
                     ka_ff <= dv_q; dv_n <= l_ff; dv_d <= bd_ff;
                  end
               endcase
               if (cur_ff == rau_pkg::DP_LCM) begin
                  sub_ff <= S_IDLE; done_ff <= 1'b1;
               end else begin
                  dv_start <= 1'b1; sub_ff <= S_DIV2;
               end
            end
            S_DIV2: if (dv_done) begin
               unique case (cur_ff)
                  rau_pkg::DP_DIV_A: ad_ff <= dv_q;
                  rau_pkg::DP_DIV_B: bd_ff <= dv_q;
                  rau_pkg::DP_DIV_R: begin
                     rd_ff <= dv_q;
                     if (rn_ff == '0) rneg_ff <= 1'b0;
                  end
                  default: kb_ff <= dv_q;
               endcase
               sub_ff <= S_IDLE; done_ff <= 1'b1;
            end
            S_MUL: begin
               if (mstep_ff == 2'd2) begin
                  mstep_ff <= 2'd0;
                  acc_ff <= '0;
                  mpair_ff <= mpair_ff + 2'd1;
                  unique case (cur_ff)
                     rau_pkg::DP_LCM: begin
                        dv_n <= acc_ff + pp; dv_d <= g_ff; dv_start <= 1'b1;
                        sub_ff <= S_DIV1;
                     end
                     rau_pkg::DP_MULS: begin
                        if (mpair_ff == 2'd0) begin
                           ka_ff <= acc_ff + pp; ma_ff <= bn_ff; mb_ff <= kb_ff;
                        end else begin
                           kb_ff <= acc_ff + pp; sub_ff <= S_IDLE; done_ff <= 1'b1;
                        end
                     end
                     default: begin
                        if (mpair_ff == 2'd0) begin
                           rn_ff <= acc_ff + pp; ma_ff <= ad_ff; mb_ff <= bd_ff;
                        end else begin
                           rd_ff <= acc_ff + pp; sub_ff <= S_IDLE; done_ff <= 1'b1;
                        end
                     end
                  endcase
               end else begin
                  acc_ff <= acc_ff + pp;
                  mstep_ff <= mstep_ff + 2'd1;
               end
            end
            default: sub_ff <= S_IDLE;
         endcase
      end
   end

   assign sts.done = done_ff;
   assign r_num = rn_ff;
   assign r_den = rd_ff;
   assign r_neg = rneg_ff;
endmodule

/* rtl/rau_ctrl.sv */
module rau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           op,
   input  logic                 den_zero,
   input  rau_pkg::dp_sts_type  sts,
   input  rau_pkg::word_type    r_num,
   input  rau_pkg::word_type    r_den,
   input  logic                 r_neg,
   output rau_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 strobe,
   output rau_pkg::word_type    o_num,
   output rau_pkg::word_type    o_den,
   output logic                 o_neg,
   output logic                 o_cmp,
   output logic                 o_err
);
   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} state_type;

   state_type state_ff;
   logic [2:0] op_ff;
   rau_pkg::cmd_type step_ff;
   logic go_ff, strobe_ff;
   rau_pkg::word_type num_ff, den_ff;
   logic neg_ff, cmp_ff, err_ff;

   function automatic rau_pkg::cmd_type next_step(rau_pkg::cmd_type s, logic is_mul);
      rau_pkg::cmd_type n;
      unique case (s)
         rau_pkg::DP_LOAD:    n = is_mul ? rau_pkg::DP_MUL : rau_pkg::DP_RED_A;
         rau_pkg::DP_RED_A:   n = rau_pkg::DP_DIV_A;
         rau_pkg::DP_DIV_A:   n = rau_pkg::DP_RED_B;
         rau_pkg::DP_RED_B:   n = rau_pkg::DP_DIV_B;
         rau_pkg::DP_DIV_B:   n = rau_pkg::DP_GCD_DEN;
         rau_pkg::DP_GCD_DEN: n = rau_pkg::DP_LCM;
         rau_pkg::DP_LCM:     n = rau_pkg::DP_SCALE;
         rau_pkg::DP_SCALE:   n = rau_pkg::DP_MULS;
         rau_pkg::DP_MULS:    n = rau_pkg::DP_COMBINE;
         rau_pkg::DP_COMBINE: n = rau_pkg::DP_RED_R;
         rau_pkg::DP_MUL:     n = rau_pkg::DP_RED_R;
         rau_pkg::DP_RED_R:   n = rau_pkg::DP_DIV_R;
         default:             n = rau_pkg::DP_NOP;
      endcase
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff <= 1'b0;
         strobe_ff <= 1'b0;
         step_ff <= rau_pkg::DP_NOP;
      end else begin
         go_ff <= 1'b0;
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (start) begin
               op_ff <= op;
               num_ff <= '0; den_ff <= '0; neg_ff <= 1'b0; cmp_ff <= 1'b0; err_ff <= 1'b0;
               if (op > 3'(rau_pkg::OP_EQ)) begin
                  state_ff <= ST_DONE;
               end else if (den_zero) begin
                  err_ff <= 1'b1; state_ff <= ST_DONE;
               end else begin
                  step_ff <= rau_pkg::DP_LOAD; go_ff <= 1'b1; state_ff <= ST_WAIT;
               end
            end
            ST_ISSUE: begin
               go_ff <= 1'b1; state_ff <= ST_WAIT;
            end
            ST_WAIT: if (sts.done) begin
               if (step_ff == rau_pkg::DP_DIV_R) begin
                  if (op_ff == 3'(rau_pkg::OP_GT))
                     cmp_ff <= (r_num != '0) && !r_neg;
                  else if (op_ff == 3'(rau_pkg::OP_EQ))
                     cmp_ff <= (r_num == '0);
                  else begin
                     num_ff <= r_num; den_ff <= r_den; neg_ff <= r_neg;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= next_step(step_ff, op_ff == 3'(rau_pkg::OP_MUL));
                  state_ff <= ST_ISSUE;
               end
            end
            ST_DONE: begin
               strobe_ff <= 1'b1; state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign cmd.go = go_ff;
   assign cmd.cmd = step_ff;
   assign busy = (state_ff != ST_IDLE) || strobe_ff;
   assign strobe = strobe_ff;
   assign o_num = num_ff;
   assign o_den = den_ff;
   assign o_neg = neg_ff;
   assign o_cmp = cmp_ff;
   assign o_err = err_ff;
endmodule

/* rtl/rational_arith_unit.sv */
// The run time is data dependent: each gcd step is one serial division with its handshake,
// and four gcds of up to about 93 steps plus nine divisions set it for add, subtract and
// compare.
// Throughput: one item at a time; busy stays high from start until the strobe cycle ends.
// Results show for one cycle on rsp_valid; the receiver cannot stall.
// Reset: synchronous, active high; clears the control state of controller, datapath and divider.
module rational_arith_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_op,
   input  rau_pkg::word_type   req_a_num,
   input  rau_pkg::word_type   req_a_den,
   input  logic                req_a_neg,
   input  rau_pkg::word_type   req_b_num,
   input  rau_pkg::word_type   req_b_den,
   input  logic                req_b_neg,
   output logic                rsp_valid,
   output rau_pkg::word_type   rsp_res_num,
   output rau_pkg::word_type   rsp_res_den,
   output logic                rsp_res_neg,
   output logic                rsp_compare_true,
   output logic                rsp_div_zero_error
);
   rau_pkg::dp_cmd_type cmd;
   rau_pkg::dp_sts_type sts;
   rau_pkg::word_type r_num, r_den;
   logic r_neg;
   logic [2:0] op_hold_ff;
   logic bneg_hold_ff;

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_hold_ff <= req_op; bneg_hold_ff <= req_b_neg;
      end
   end

   rau_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start && !busy), .op(req_op),
      .den_zero(req_a_den == '0 || req_b_den == '0), .sts(sts),
      .r_num(r_num), .r_den(r_den), .r_neg(r_neg), .cmd(cmd), .busy(busy),
      .strobe(rsp_valid), .o_num(rsp_res_num), .o_den(rsp_res_den),
      .o_neg(rsp_res_neg), .o_cmp(rsp_compare_true), .o_err(rsp_div_zero_error)
   );

   // operands are captured by the LOAD step the cycle after start, so hold them
   rau_pkg::word_type an_h, ad_h, bn_h, bd_h;
   logic an_neg_h;
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         an_h <= req_a_num; ad_h <= req_a_den; an_neg_h <= req_a_neg;
         bn_h <= req_b_num; bd_h <= req_b_den;
      end
   end

   rau_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .op(op_hold_ff),
      .a_num_i(an_h), .a_den_i(ad_h), .a_neg_i(an_neg_h),
      .b_num_i(bn_h), .b_den_i(bd_h), .b_neg_i(bneg_hold_ff),
      .r_num(r_num), .r_den(r_den), .r_neg(r_neg)
   );
endmodule

/* rtl/rau_checker.sv */
module rau_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input rau_pkg::word_type   rsp_res_num,
   input rau_pkg::word_type   rsp_res_den,
   input logic                rsp_res_neg,
   input logic                rsp_compare_true,
   input logic                rsp_div_zero_error
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("no busy after accepted beat");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat longer than a cycle");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero_error |->
         rsp_res_num == '0 && rsp_res_den == '0 && !rsp_compare_true)
      else $error("error beat carries data");
   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_res_num == '0 |-> !rsp_res_neg) else $error("negative zero");
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den), .rsp_res_neg(rsp_res_neg),
   .rsp_compare_true(rsp_compare_true), .rsp_div_zero_error(rsp_div_zero_error)
);

/* verif/rational_arith_unit_tb.sv */
`timescale 1ns / 1ps

module rational_arith_unit_tb;

   typedef struct {
      rau_pkg::word_type num;
      rau_pkg::word_type den;
      logic              neg;
      logic              cmp;
      logic              dz;
   } rat_result_type;

   typedef struct {
      rau_pkg::word_type num;
      rau_pkg::word_type den;
      logic              neg;
   } rational_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [2:0]        req_op;
   rau_pkg::word_type req_a_num, req_a_den, req_b_num, req_b_den;
   logic              req_a_neg, req_b_neg;
   logic              rsp_valid;
   rau_pkg::word_type rsp_res_num, rsp_res_den;
   logic              rsp_res_neg, rsp_compare_true, rsp_div_zero_error;

   rat_result_type expected_q[$];
   int             errors;
   int             beats_sent;
   int             beats_checked;
   int             gap_pct;

   rational_arith_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rau_pkg::word_type gcd_w(rau_pkg::word_type x, rau_pkg::word_type y);
      rau_pkg::word_type r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return (x == 0) ? rau_pkg::word_type'(1) : x;
   endfunction

   function automatic rational_type reduce_rat(rational_type v);
      rau_pkg::word_type g;
      g = gcd_w(v.num, v.den);
      v.num = v.num / g;
      v.den = v.den / g;
      if (v.num == 0) v.neg = 1'b0;
      return v;
   endfunction

   function automatic rational_type add_rat(rational_type a, rational_type b);
      rational_type      r;
      rau_pkg::word_type g, l, sa, sb;
      a = reduce_rat(a);
      b = reduce_rat(b);
      g = gcd_w(a.den, b.den);
      l = rau_pkg::word_type'(a.den * b.den) / g;
      sa = rau_pkg::word_type'(a.num * (l / a.den));
      sb = rau_pkg::word_type'(b.num * (l / b.den));
      if (a.neg == b.neg) begin
         r.num = sa + sb;
         r.neg = a.neg;
      end else if (sa >= sb) begin
         r.num = sa - sb;
         r.neg = a.neg;
      end else begin
         r.num = sb - sa;
         r.neg = b.neg;
      end
      r.den = l;
      if (r.num == 0) r.neg = 1'b0;
      return reduce_rat(r);
   endfunction

   function automatic rat_result_type predict_rational(logic [2:0] op, rational_type a,
                                                        rational_type b);
      rat_result_type e;
      rational_type   r;
      e = '{default: '0};
      if (op > rau_pkg::OP_EQ) return e;
      if (a.den == 0 || b.den == 0) begin
         e.dz = 1'b1;
         return e;
      end
      if (op == rau_pkg::OP_MUL) begin
         r.num = a.num * b.num;
         r.den = a.den * b.den;
         r.neg = a.neg ^ b.neg;
         r = reduce_rat(r);
      end else begin
         if (op != rau_pkg::OP_ADD) b.neg = ~b.neg;
         r = add_rat(a, b);
      end
      if (op == rau_pkg::OP_GT) e.cmp = (r.num != 0) && !r.neg;
      else if (op == rau_pkg::OP_EQ) e.cmp = (r.num == 0);
      else begin
         e.num = r.num;
         e.den = r.den;
         e.neg = r.neg;
      end
      return e;
   endfunction

   // one beat, driven on the falling edge and held until accepted
   task automatic send_rational(logic [2:0] op, rational_type a, rational_type b);
      @(negedge clock);
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(negedge clock);
      start     <= 1'b1;
      req_op    <= op;
      req_a_num <= a.num;
      req_a_den <= a.den;
      req_a_neg <= a.neg;
      req_b_num <= b.num;
      req_b_den <= b.den;
      req_b_neg <= b.neg;
      // busy only moves at the rising edge, so it is stable here
      while (busy) @(negedge clock);
      @(posedge clock);
      expected_q.push_back(predict_rational(op, a, b));
      beats_sent++;
      @(negedge clock);
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected", $time);
            errors++;
         end else begin
            rat_result_type e;
            e = expected_q.pop_front();
            beats_checked++;
            if (rsp_res_num !== e.num) begin
               $display("%0t: res_num exp %h got %h", $time, e.num, rsp_res_num);
               errors++;
            end
            if (rsp_res_den !== e.den) begin
               $display("%0t: res_den exp %h got %h", $time, e.den, rsp_res_den);
               errors++;
            end
            if (rsp_res_neg !== e.neg) begin
               $display("%0t: res_neg exp %b got %b", $time, e.neg, rsp_res_neg);
               errors++;
            end
            if (rsp_compare_true !== e.cmp) begin
               $display("%0t: compare_true exp %b got %b", $time, e.cmp,
                        rsp_compare_true);
               errors++;
            end
            if (rsp_div_zero_error !== e.dz) begin
               $display("%0t: div_zero_error exp %b got %b", $time, e.dz,
                        rsp_div_zero_error);
               errors++;
            end
         end
      end
   end

   function automatic rational_type mk(rau_pkg::word_type n, rau_pkg::word_type d, logic s);
      rational_type v;
      v.num = n;
      v.den = d;
      v.neg = s;
      return v;
   endfunction

   function automatic rau_pkg::word_type rand_word(int mode);
      case (mode)
         0: return rau_pkg::word_type'($urandom_range(1, 60));
         1: return rau_pkg::word_type'($urandom_range(1, 5000));
         2: return {$urandom, $urandom};
         default: return rau_pkg::word_type'($urandom);
      endcase
   endfunction

   task automatic wait_drained();
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      rau_pkg::word_type mx;
      logic [2:0]        op;
      mx = '1;
      for (int k = 0; k < 5; k++) begin
         op = k[2:0];
         send_rational(op, mk(1, 2, 0), mk(1, 3, 1));
      end
      send_rational(rau_pkg::OP_ADD, mk(mx, mx, 1), mk(mx, 1, 0));
      send_rational(rau_pkg::OP_MUL, mk(mx, mx - 1, 0), mk(mx, 3, 1));
      send_rational(rau_pkg::OP_ADD, mk(0, 5, 1), mk(0, 7, 1));   // zero stays positive
      send_rational(rau_pkg::OP_SUB, mk(3, 4, 1), mk(6, 8, 1));
      send_rational(rau_pkg::OP_EQ, mk(2, 4, 0), mk(1, 2, 0));
      send_rational(rau_pkg::OP_GT, mk(1, 2, 1), mk(1, 3, 1));
      send_rational(rau_pkg::OP_GT, mk(5, 5, 0), mk(1, 1, 0));
      send_rational(rau_pkg::OP_ADD, mk(1, 0, 0), mk(1, 1, 0));   // zero denominators
      send_rational(rau_pkg::OP_EQ, mk(1, 1, 0), mk(1, 0, 1));
      send_rational(rau_pkg::OP_MUL, mk(0, 0, 1), mk(0, 0, 1));
      send_rational(3'd5, mk(1, 2, 1), mk(3, 4, 0));            // undefined ops
      send_rational(3'd6, mk(1, 0, 1), mk(3, 0, 0));
      send_rational(3'd7, mk(mx, mx, 1), mk(mx, mx, 1));
      // denominator product wraps to zero
      send_rational(rau_pkg::OP_MUL, mk(3, 64'h1_0000_0000, 0),
                    mk(5, 64'h1_0000_0000, 0));
      send_rational(rau_pkg::OP_ADD, mk(1, 64'h8000_0000_0000_0000, 0),
                    mk(1, 64'h3, 0));
      send_rational(rau_pkg::OP_SUB, mk(mx, 1, 0), mk(mx, 1, 1));
   endtask

   task automatic test_random(int count);
      rational_type a, b;
      logic [2:0]   op;
      int           mode;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(3);
         op = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
         a = mk(rand_word(mode), rand_word($urandom_range(3)), 1'($urandom_range(1)));
         b = mk(rand_word(mode), rand_word($urandom_range(3)), 1'($urandom_range(1)));
         if ($urandom_range(9) == 0) a.num = 0;
         if ($urandom_range(24) == 0) a.den = 0;
         if ($urandom_range(24) == 0) b.den = 0;
         if ($urandom_range(9) == 0) b = a;                    // equal operands
         send_rational(op, a, b);
      end
   endtask

   initial begin
      errors = 0;
      beats_sent = 0;
      beats_checked = 0;
      gap_pct = 0;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_op = '0;
      req_a_num = '0;
      req_a_den = '0;
      req_a_neg = 1'b0;
      req_b_num = '0;
      req_b_den = '0;
      req_b_neg = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_directed();
      gap_pct = 12;
      test_random(90);
      wait_drained();
      gap_pct = 55;
      test_random(90);
      gap_pct = 0;
      test_random(90);
      wait_drained();
      repeat (20) @(negedge clock);
      $display("Sent %0d beats covering all ops, zero denominators, wraps and undefined ops;",
               beats_sent);
      $display("checked %0d results.", beats_checked);
      if (errors == 0) begin
         $display("[rational_arith_unit] OK");
      end else begin
         $display("[rational_arith_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("[rational_arith_unit] ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arith_unit.sv
rtl/rau_checker.sv
verif/rational_arith_unit_tb.sv
